// File: sv/wlq_pkg.sv
// Shared types and constants for the three-channel windowed level qualifier.
`timescale 1ns / 1ps

package wlq_pkg;

	// Number of qualified channels: bit0 sods, bit1 soe, bit2 lo
	localparam int unsigned NumCh = 3;

	// Window counter and length width
	localparam int unsigned WinW = 16;

	// Per-channel high-sample counter width
	localparam int unsigned CntW = 17;

	// Product width for 10 * count against 9 * length
	localparam int unsigned ProdW = CntW + 4;

	// One result beat
	typedef struct packed {
		logic [NumCh-1:0] levels;
		logic             window_done;
		logic             changed_now;
		logic             change_pending;
	} result_t;

endpackage

// File: sv/wlq_obuf.sv
// Two-entry result buffer that decouples the qualifier core from a stalled receiver.
`timescale 1ns / 1ps

module wlq_obuf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  wlq_pkg::result_t d,
	output logic            space,
	output logic            out_valid,
	input  logic            out_ready,
	output wlq_pkg::result_t q
);

	wlq_pkg::result_t head_q;
	wlq_pkg::result_t tail_q;
	logic [1:0]       cnt_q;
	logic             pop;

	// Occupancy decode
	assign space     = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign q         = head_q;
	assign pop       = out_valid & out_ready;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			priority if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Load head from the incoming beat or advance the tail into it
	always_ff @(posedge clk) begin
		priority if (push && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop))) begin
			head_q <= d;
		end else if (pop && (cnt_q == 2'd2)) begin
			head_q <= tail_q;
		end
		if (push && (cnt_q == 2'd1) && !pop) begin
			tail_q <= d;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result buffer occupancy out of range");

	a_tail_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) && pop |=> head_q == $past(tail_q))
		else $error("held beat not advanced to head");

	a_empty_load: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) && push |=> (cnt_q == 2'd1) && (head_q == $past(d)))
		else $error("beat into empty buffer not presented");

endmodule

// File: sv/windowed_level_qualifier_3ch.sv
// Top level of the three-channel windowed level qualifier with its APB register port.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per tick: action = 0 is a
//   sample of the sods, soe and lo pins, action = 1 acknowledges and clears the
//   sticky change flag. Each enabled channel counts high samples over a window of
//   window_length + 1 ticks; at the close a channel is qualified high when
//   10 * count > 9 * window_length.
//   Output channel (out_valid/out_ready) returns exactly one beat per input beat:
//   the qualified levels, window_done, changed_now and change_pending.
//   Each result is registered in the result buffer and reaches out_valid behind any
//   results held there; throughput is one beat per cycle while out_ready stays high.
//   A two-entry result buffer keeps in_ready high while one result waits, so the
//   input stalls only when two results are held by a stalled receiver.
//   Reset clears counters, levels and the sticky flag and loads window_length = 100
//   and channel_enable = 7. Registers: window_length at 0x0, channel_enable at 0x4.
`timescale 1ns / 1ps

module windowed_level_qualifier_3ch (
	input  logic        clk,
	input  logic        arst_n,
	// APB register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic        sods_pin,
	input  logic        soe_pin,
	input  logic        lo_pin,
	// Output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        sods_level,
	output logic        soe_level,
	output logic        lo_level,
	output logic        window_done,
	output logic        changed_now,
	output logic        change_pending
);

	localparam int unsigned NumCh = wlq_pkg::NumCh;
	localparam int unsigned WinW  = wlq_pkg::WinW;
	localparam int unsigned CntW  = wlq_pkg::CntW;
	localparam int unsigned ProdW = wlq_pkg::ProdW;

	localparam logic RegWindowLength  = 1'b0;
	localparam logic RegChannelEnable = 1'b1;

	localparam logic [WinW-1:0]  LenReset = 16'd100;
	localparam logic [NumCh-1:0] EnReset  = 3'b111;

	localparam logic ActSample = 1'b0;
	localparam logic ActAck    = 1'b1;

	logic [WinW-1:0]  window_length_q;
	logic [NumCh-1:0] channel_enable_q;
	logic [WinW-1:0]  window_count_q;
	logic [CntW-1:0]  high_count_q [NumCh];
	logic [NumCh-1:0] levels_q;
	logic             sticky_q;

	logic             cfg_wr;
	logic             accept;
	logic             sample;
	logic             close;
	logic [NumCh-1:0] pins;
	logic [CntW-1:0]  count_nx [NumCh];
	logic [NumCh-1:0] qual;
	logic [ProdW-1:0] len_x9;
	logic             chg;
	wlq_pkg::result_t res;
	wlq_pkg::result_t res_out;

	// Register port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q  <= LenReset;
			channel_enable_q <= EnReset;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				RegWindowLength:  window_length_q  <= pwdata[WinW-1:0];
				RegChannelEnable: channel_enable_q <= pwdata[NumCh-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			RegWindowLength:  prdata = {{(32-WinW){1'b0}}, window_length_q};
			RegChannelEnable: prdata = {{(32-NumCh){1'b0}}, channel_enable_q};
			default:          prdata = '0;
		endcase
	end

	// Qualify: bump enabled counts and compare 10 * count against 9 * length
	assign accept = in_valid & in_ready;
	assign sample = accept & (action == ActSample);
	assign pins   = {lo_pin, soe_pin, sods_pin};
	assign close  = (window_count_q >= window_length_q);
	assign len_x9 = ({{(ProdW-WinW){1'b0}}, window_length_q} << 3)
	              + {{(ProdW-WinW){1'b0}}, window_length_q};

	always_comb begin
		logic [ProdW-1:0] cnt_x10;
		for (int i = 0; i < NumCh; i++) begin
			cnt_x10 = '0;
			if (channel_enable_q[i] && pins[i] && (high_count_q[i] != {CntW{1'b1}})) begin
				count_nx[i] = high_count_q[i] + {{(CntW-1){1'b0}}, 1'b1};
			end else begin
				count_nx[i] = high_count_q[i];
			end
			cnt_x10 = ({{(ProdW-CntW){1'b0}}, count_nx[i]} << 3)
			        + ({{(ProdW-CntW){1'b0}}, count_nx[i]} << 1);
			qual[i] = (cnt_x10 > len_x9);
		end
	end

	assign chg = close & (qual != levels_q);

	// Advance window state on each accepted sample beat; an acknowledge clears the sticky flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_count_q <= '0;
			levels_q       <= '0;
			sticky_q       <= 1'b0;
			for (int i = 0; i < NumCh; i++) begin
				high_count_q[i] <= '0;
			end
		end else if (accept) begin
			if (action == ActAck) begin
				sticky_q <= 1'b0;
			end else if (close) begin
				window_count_q <= '0;
				levels_q       <= qual;
				if (chg) begin
					sticky_q <= 1'b1;
				end
				for (int i = 0; i < NumCh; i++) begin
					high_count_q[i] <= '0;
				end
			end else begin
				window_count_q <= window_count_q + {{(WinW-1){1'b0}}, 1'b1};
				for (int i = 0; i < NumCh; i++) begin
					high_count_q[i] <= count_nx[i];
				end
			end
		end
	end

	// Build the result beat for this item
	always_comb begin
		res = '0;
		if (action == ActAck) begin
			res.levels         = levels_q;
			res.change_pending = sticky_q;
		end else begin
			res.levels         = close ? qual : levels_q;
			res.window_done    = close;
			res.changed_now    = chg;
			res.change_pending = sticky_q | chg;
		end
	end

	wlq_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.d         (res),
		.space     (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.q         (res_out)
	);

	assign sods_level     = res_out.levels[0];
	assign soe_level      = res_out.levels[1];
	assign lo_level       = res_out.levels[2];
	assign window_done    = res_out.window_done;
	assign changed_now    = res_out.changed_now;
	assign change_pending = res_out.change_pending;

	a_ack_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (action == ActAck) |=> !sticky_q)
		else $error("acknowledge did not clear sticky flag");

	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		sample && close |=> (window_count_q == '0) && (high_count_q[0] == '0)
			&& (high_count_q[1] == '0) && (high_count_q[2] == '0))
		else $error("window close did not clear counters");

	a_count_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!sample |=> $stable(window_count_q) && $stable(levels_q))
		else $error("window state moved without a sample");

endmodule

// File: sim/wlq_level_checker.sv
// Checker that predicts and compares every result beat of the windowed level qualifier.
`timescale 1ns / 1ps

module wlq_level_checker #(
	parameter logic [2:0] LenAddr    = 3'h0,
	parameter logic [2:0] EnAddr     = 3'h4,
	parameter logic       AckAction  = 1'b1,
	parameter int         LenAtReset = 100
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        action,
	input  logic        sods_pin,
	input  logic        soe_pin,
	input  logic        lo_pin,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        sods_level,
	input  logic        soe_level,
	input  logic        lo_level,
	input  logic        window_done,
	input  logic        changed_now,
	input  logic        change_pending,
	output int          fail_count,
	output int          results_owed
);

	localparam int unsigned NumCh = wlq_pkg::NumCh;
	localparam int unsigned WinW  = wlq_pkg::WinW;
	localparam int unsigned CntW  = wlq_pkg::CntW;
	localparam int unsigned ProdW = wlq_pkg::ProdW;

	localparam logic [NumCh-1:0] EnAtReset = 3'h7;
	localparam int ChSods = 0;
	localparam int ChSoe  = 1;
	localparam int ChLo   = 2;
	// Qualification ratio 9/10, compared as 10 * count > 9 * length
	localparam int RatioNum = 9;
	localparam int RatioDen = 10;
	localparam int PrintCap = 100;

	// Shadow of the register file
	logic [WinW-1:0]  win_len;
	logic [NumCh-1:0] ch_en;

	// Shadow of the filter state
	logic [WinW-1:0]  win_pos;
	logic [CntW-1:0]  hi_cnt [NumCh];
	logic [NumCh-1:0] levels;
	logic             sticky;

	wlq_pkg::result_t level_reports [$];
	int miscount = 0;
	int beat_no  = 0;

	assign fail_count = miscount;

	task automatic flag_mismatch(input string msg);
		miscount++;
		if (miscount <= PrintCap)
			$display("%0t ns: result beat %0d: %s", $time, beat_no, msg);
	endtask

	task automatic check_bit(input string what, input logic got, input logic want);
		if (got !== want)
			flag_mismatch($sformatf("%s got %b want %b", what, got, want));
	endtask

	// Advance the filter by one input beat and return the result it causes
	task automatic qualify_beat(input logic act, input logic [NumCh-1:0] pins,
			output wlq_pkg::result_t r);
		logic [NumCh-1:0] next;
		logic done;
		logic chg;
		logic flag;
		done = 1'b0;
		chg  = 1'b0;
		if (act == AckAction) begin
			// Report the sticky flag, then clear it; counters hold
			flag   = sticky;
			sticky = 1'b0;
		end else begin
			// Count high samples on enabled channels, saturating
			for (int c = 0; c < NumCh; c++) begin
				if (ch_en[c] && pins[c] && hi_cnt[c] != {CntW{1'b1}})
					hi_cnt[c] = hi_cnt[c] + CntW'(1);
			end
			if (win_pos < win_len) begin
				win_pos = win_pos + WinW'(1);
			end else begin
				// Close the window: requalify, then clear counts
				for (int c = 0; c < NumCh; c++)
					next[c] = (ProdW'(hi_cnt[c]) * ProdW'(RatioDen)) >
						(ProdW'(win_len) * ProdW'(RatioNum));
				done = 1'b1;
				if (next != levels) begin
					chg    = 1'b1;
					sticky = 1'b1;
				end
				levels  = next;
				win_pos = '0;
				for (int c = 0; c < NumCh; c++)
					hi_cnt[c] = '0;
			end
			flag = sticky;
		end
		r.levels         = levels;
		r.window_done    = done;
		r.changed_now    = chg;
		r.change_pending = flag;
	endtask

	// Watch the register port and both channels
	always @(posedge clk or negedge arst_n) begin
		wlq_pkg::result_t got;
		wlq_pkg::result_t want;
		if (!arst_n) begin
			win_len = WinW'(LenAtReset);
			ch_en   = EnAtReset;
			win_pos = '0;
			for (int c = 0; c < NumCh; c++)
				hi_cnt[c] = '0;
			levels = '0;
			sticky = 1'b0;
			level_reports.delete();
			results_owed <= 0;
		end else begin
			// Mirror register writes
			if (psel && penable && pwrite && pready) begin
				if (paddr == LenAddr)
					win_len = pwdata[WinW-1:0];
				else if (paddr == EnAddr)
					ch_en = pwdata[NumCh-1:0];
			end
			// Compare an outgoing beat with the oldest prediction
			if (out_valid && out_ready) begin
				got.levels         = {lo_level, soe_level, sods_level};
				got.window_done    = window_done;
				got.changed_now    = changed_now;
				got.change_pending = change_pending;
				if (level_reports.size() == 0) begin
					flag_mismatch("result beat with nothing expected");
				end else begin
					want = level_reports.pop_front();
					check_bit("sods_level", got.levels[ChSods], want.levels[ChSods]);
					check_bit("soe_level", got.levels[ChSoe], want.levels[ChSoe]);
					check_bit("lo_level", got.levels[ChLo], want.levels[ChLo]);
					check_bit("window_done", got.window_done, want.window_done);
					check_bit("changed_now", got.changed_now, want.changed_now);
					check_bit("change_pending", got.change_pending, want.change_pending);
				end
				beat_no++;
			end
			// Predict the result of an accepted input beat
			if (in_valid && in_ready) begin
				qualify_beat(action, {lo_pin, soe_pin, sods_pin}, want);
				level_reports.push_back(want);
			end
			results_owed <= level_reports.size();
		end
	end

endmodule

// File: sim/windowed_level_qualifier_3ch_test.sv
// Stimulus and verdict for the three-channel windowed level qualifier.
`timescale 1ns / 1ps

module windowed_level_qualifier_3ch_test;

	localparam int NumCh = wlq_pkg::NumCh;
	localparam int WinW  = wlq_pkg::WinW;

	localparam logic [2:0] RegWindowLength  = 3'h0;
	localparam logic [2:0] RegChannelEnable = 3'h4;
	localparam logic ActSample = 1'b0;
	localparam logic ActAck    = 1'b1;
	localparam int LenAtReset  = 100;
	localparam int MaxLen      = (1 << WinW) - 1;
	localparam int RatioNum    = 9;
	localparam int RatioDen    = 10;
	localparam int RandomBeats = 1150;
	localparam int CycleLimit  = 1000000;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	logic        action;
	logic        sods_pin;
	logic        soe_pin;
	logic        lo_pin;
	logic        out_valid;
	logic        out_ready;
	logic        sods_level;
	logic        soe_level;
	logic        lo_level;
	logic        window_done;
	logic        changed_now;
	logic        change_pending;

	int fail_count;
	int results_owed;

	// Stimulus-side view of the window position, used only to shape windows
	int cur_len    = LenAtReset;
	int win_pos    = 0;
	int beats_sent = 0;
	int cycle_count = 0;
	bit burst = 1'b0;

	windowed_level_qualifier_3ch dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.sods_pin(sods_pin),
		.soe_pin(soe_pin),
		.lo_pin(lo_pin),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sods_level(sods_level),
		.soe_level(soe_level),
		.lo_level(lo_level),
		.window_done(window_done),
		.changed_now(changed_now),
		.change_pending(change_pending)
	);

	wlq_level_checker #(
		.LenAddr(RegWindowLength),
		.EnAddr(RegChannelEnable),
		.AckAction(ActAck),
		.LenAtReset(LenAtReset)
	) filter_check (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.sods_pin(sods_pin),
		.soe_pin(soe_pin),
		.lo_pin(lo_pin),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sods_level(sods_level),
		.soe_level(soe_level),
		.lo_level(lo_level),
		.window_done(window_done),
		.changed_now(changed_now),
		.change_pending(change_pending),
		.fail_count(fail_count),
		.results_owed(results_owed)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// End the run if it hangs
	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("windowed_level_qualifier_3ch_test: done, errors");
		$finish;
	end

	// Fewest high samples that qualify a channel for a given length
	function automatic int qual_min(input int len);
		return (RatioNum * len) / RatioDen + 1;
	endfunction

	// Samples left before the current window closes
	function automatic int window_left();
		return (win_pos > cur_len) ? 1 : cur_len - win_pos + 1;
	endfunction

	// Choose a high count for a window, mostly around the threshold
	function automatic int pick_highs(input int n, input int len);
		int k;
		case ($urandom_range(5))
			0: k = qual_min(len) - 1;
			1: k = qual_min(len);
			2: k = qual_min(len) + 1;
			3: k = 0;
			4: k = n;
			default: k = $urandom_range(n);
		endcase
		if (k < 0)
			k = 0;
		if (k > n)
			k = n;
		return k;
	endfunction

	// Drive one input beat after a random gap
	task automatic send_beat(input logic act, input logic [NumCh-1:0] pins);
		int gap;
		gap = burst ? 0 : $urandom_range(15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		{lo_pin, soe_pin, sods_pin} <= pins;
		do @(posedge clk); while (!in_ready);
		if (act == ActSample)
			win_pos = (win_pos < cur_len) ? win_pos + 1 : 0;
		beats_sent++;
	endtask

	// Drop valid, then wait until every predicted result has come back
	task automatic settle_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
	endtask

	// Two-phase register write
	task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Load both registers once the block is idle; junk goes in the unused bits
	task automatic reconfigure(input int len, input logic [NumCh-1:0] en);
		logic [31:0] junk;
		settle_results();
		junk = $urandom;
		write_reg(RegWindowLength, {junk[31:WinW], WinW'(len)});
		junk = $urandom;
		write_reg(RegChannelEnable, {junk[31:NumCh], en});
		cur_len = len;
	endtask

	// Send n samples with exact per-channel high counts, acks mixed in
	task automatic drive_window(input int n, input int k_sods, input int k_soe,
			input int k_lo, input int ack_odds);
		int want [NumCh];
		logic [NumCh-1:0] pins;
		want = '{k_sods, k_soe, k_lo};
		for (int i = 0; i < n; i++) begin
			if (ack_odds > 0 && $urandom_range(ack_odds - 1) == 0)
				send_beat(ActAck, NumCh'($urandom));
			for (int c = 0; c < NumCh; c++) begin
				pins[c] = ($urandom_range(n - i - 1) < want[c]);
				if (pins[c])
					want[c]--;
			end
			send_beat(ActSample, pins);
		end
	endtask

	// Receiver: stall a random number of cycles before each result beat
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = burst ? 0 : $urandom_range(15);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Sender: directed beats, a window cut short at the longest length, then random phases
	initial begin
		int n;
		int windows;
		int len;
		logic [NumCh-1:0] en;
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		in_valid = 1'b0;
		action   = ActSample;
		sods_pin = 1'b0;
		soe_pin  = 1'b0;
		lo_pin   = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Ack with nothing pending, then part of a default-length window
		send_beat(ActAck, 3'b111);
		repeat (3) send_beat(ActSample, 3'b111);
		repeat (2) send_beat(ActSample, 3'b000);
		// Lower the length below the running count: next tick closes
		reconfigure(3, 3'b111);
		send_beat(ActSample, 3'b111);
		send_beat(ActAck, 3'b010);
		send_beat(ActAck, 3'b101);
		// Zero length closes every tick; soe disabled
		reconfigure(0, 3'b101);
		send_beat(ActSample, 3'b111);
		send_beat(ActSample, 3'b000);
		send_beat(ActSample, 3'b001);
		send_beat(ActAck, 3'b000);
		// Shortest real window with every channel disabled
		reconfigure(1, 3'b000);
		repeat (2) send_beat(ActSample, 3'b111);
		send_beat(ActAck, 3'b111);

		// Longest length; leave a window open so the next phase shortens it
		reconfigure(MaxLen, 3'b111);
		drive_window(10, pick_highs(10, MaxLen), $urandom_range(10), 10, 4);

		// Random phases of well-formed windows, some cut short
		while (beats_sent < RandomBeats) begin
			case ($urandom_range(9))
				0: len = 0;
				1: len = 1;
				2, 3, 4, 5: len = $urandom_range(12, 2);
				6, 7, 8: len = $urandom_range(40, 13);
				default: len = $urandom_range(300, 41);
			endcase
			en = ($urandom_range(3) == 0) ? 3'b111 : NumCh'($urandom);
			reconfigure(len, en);
			burst = ($urandom_range(3) == 0);
			windows = 1 + 60 / (len + 1);
			for (int w = 0; w < windows; w++) begin
				n = window_left();
				if (w == windows - 1 && $urandom_range(2) == 0)
					n = $urandom_range(n, 1);
				drive_window(n, pick_highs(n, cur_len), pick_highs(n, cur_len),
					pick_highs(n, cur_len), 8);
			end
		end
		burst = 1'b0;

		// Drain, then wait for stray beats to show up
		settle_results();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("windowed_level_qualifier_3ch_test: done, clean");
		else
			$display("windowed_level_qualifier_3ch_test: done, errors");
		$finish;
	end

endmodule
